### hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int TEXT_ROWS = 30;
  localparam int TEXT_COLS = 40;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 6;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);

  // character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QMARK = 8'd63;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // output modes
  localparam logic [1:0] MODE_SERIAL  = 2'd0;
  localparam logic [1:0] MODE_DISPLAY = 2'd1;
  localparam logic [1:0] MODE_MIRROR  = 2'd2;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_byte;
    logic             cell_valid;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [6:0]       cell_char;
    logic             scrolled;
    logic             cleared;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_CR,
    CUR_LF,
    CUR_BS,
    CUR_HOME
  } cur_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] bs_col;
    logic             adv_scroll;
    logic             lf_scroll;
  } cur_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

endpackage

### hw/rtl/tcce_cursor.sv
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor register pair with one shared step unit: advance, wrap, newline,
// carriage return, backspace and home, one command per cycle.
// ----------------------------------------------------------------------------
module tcce_cursor import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cur_cmd_t  cmd,
  output cur_stat_t stat
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             at_last_col;
  logic             at_last_row;
  logic [ROW_W-1:0] down_row;

  assign at_last_col = (col_r == LAST_COL);
  assign at_last_row = (row_r == LAST_ROW);
  // stay on the last row when the screen scrolls
  assign down_row    = at_last_row ? row_r : row_r + ROW_W'(1);

  assign stat.col        = col_r;
  assign stat.row        = row_r;
  assign stat.bs_col     = (col_r == '0) ? col_r : col_r - COL_W'(1);
  assign stat.adv_scroll = at_last_col && at_last_row;
  assign stat.lf_scroll  = at_last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (cmd)
      CUR_HOLD: ;
      CUR_ADV: begin
        if (at_last_col) begin
          col_nxt = '0;
          row_nxt = down_row;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CUR_CR: col_nxt = '0;
      CUR_LF: begin
        col_nxt = '0;
        row_nxt = down_row;
      end
      CUR_BS: col_nxt = stat.bs_col;
      CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### hw/rtl/text_console_cursor_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console engine: echo, cursor control, tab expansion, cell writes and
// scroll/clear events for a downstream renderer.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  in       | in_valid/in_ready, in_data     | one request: opcode, char_code
//  out      | out_valid/out_ready, out_data  | one result per beat, last flag
//  cfg      | psel/penable/pwrite/paddr/...  | output_mode register at 0x0
//
//  A request is accepted while idle and then gives one result per beat; a tab
//  in mirror mode gives up to five results (the echo plus four spaces). The cursor step unit
//  handles one result per cycle unless out_ready stalls. Reset homes the cursor and sets mirror
//  mode; there is no clearing pass. A stalled out_ready holds the sequencer.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t     state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       op_r, op_nxt;
  logic [7:0] code_r, code_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic       tab_echo_r, tab_echo_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_data_r, out_data_nxt;

  cur_cmd_t   cmd;
  cur_stat_t  stat;
  res_t       res;
  logic [7:0] in_code;
  logic       echo_en;
  logic [2:0] tab_spaces;
  logic [6:0] put_char;

  tcce_cursor u_cursor (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = {30'd0, mode_r};

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      // saturate the unused code to mirror
      mode_nxt = (pwdata[1:0] == 2'd3) ? MODE_MIRROR : pwdata[1:0];
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign in_code    = (in_data.char_code == CH_DEL) ? CH_BS : in_data.char_code;
  assign echo_en    = (mode_r != MODE_DISPLAY);
  assign tab_spaces = 3'd4 - {1'b0, stat.col[1:0]};
  assign put_char   = ((code_r < CH_SPACE) || (code_r > CH_TILDE)) ?
                      CH_QMARK[6:0] : code_r[6:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    code_nxt      = code_r;
    rem_nxt       = rem_r;
    tab_echo_nxt  = tab_echo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd           = CUR_HOLD;
    res           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.opcode;
          code_nxt     = in_code;
          tab_echo_nxt = 1'b0;
          rem_nxt      = 3'd1;
          if ((in_data.opcode == OP_PUT) && (mode_r != MODE_SERIAL) &&
              (in_code == CH_TAB)) begin
            // count is fixed from the column before any space is written
            tab_echo_nxt = echo_en;
            rem_nxt      = tab_spaces + {2'd0, echo_en};
          end
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!out_valid_r || out_ready) begin
          if (op_r == OP_CLEAR) begin
            res.cleared = (mode_r != MODE_SERIAL);
            cmd         = CUR_HOME;
          end else if (mode_r == MODE_SERIAL) begin
            res.echo_valid = 1'b1;
            res.echo_byte  = code_r;
          end else begin
            res.echo_valid = echo_en;
            res.echo_byte  = echo_en ? code_r : 8'd0;
            case (code_r)
              CH_CR: cmd = CUR_CR;
              CH_LF: begin
                res.scrolled = stat.lf_scroll;
                cmd          = CUR_LF;
              end
              CH_BS: begin
                res.cell_valid = 1'b1;
                res.cell_row   = stat.row;
                res.cell_col   = stat.bs_col;
                res.cell_char  = CH_SPACE[6:0];
                cmd            = CUR_BS;
              end
              CH_TAB: begin
                if (tab_echo_r) begin
                  tab_echo_nxt = 1'b0;
                end else begin
                  res.echo_byte  = echo_en ? CH_SPACE : 8'd0;
                  res.cell_valid = 1'b1;
                  res.cell_row   = stat.row;
                  res.cell_col   = stat.col;
                  res.cell_char  = CH_SPACE[6:0];
                  res.scrolled   = stat.adv_scroll;
                  cmd            = CUR_ADV;
                end
              end
              default: begin
                res.cell_valid = 1'b1;
                res.cell_row   = stat.row;
                res.cell_col   = stat.col;
                res.cell_char  = put_char;
                res.scrolled   = stat.adv_scroll;
                cmd            = CUR_ADV;
              end
            endcase
          end
          res.last      = (rem_r == 3'd1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          rem_nxt       = rem_r - 3'd1;
          if (res.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_MIRROR;
      rem_r       <= '0;
      tab_echo_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      rem_r       <= rem_nxt;
      tab_echo_r  <= tab_echo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    code_r     <= code_nxt;
    out_data_r <= out_data_nxt;
  end

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in flight");

  a_clear_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.cleared) |-> out_data.last)
    else $error("clear result not marked last");

  a_cell_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.cell_valid) |->
      (out_data.cell_col == '0 && out_data.cell_row == '0 && out_data.cell_char == '0))
    else $error("cell fields set without a cell write");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.col <= LAST_COL) && (stat.row <= LAST_ROW))
    else $error("cursor out of range");

endmodule

### verif/tb_text_console_cursor_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_unit
// Self-checking bench for the text console engine. A table of directed
// requests is followed by random text, newline and noise segments under
// changing output modes. The sender runs in bursts and the receiver stalls
// on its own pattern. Each result is checked against a fixed table entry
// or a cycle-free model of cursor, scroll offset and character store.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_unit;
  import tcce_pkg::*;

  localparam logic [2:0] REG_OUTPUT_MODE = 3'd0;
  localparam logic [1:0] MODE_RESERVED   = 2'd3;
  localparam int         RAND_REQS       = 185;
  localparam int         HOLD_AT_REQ     = 40;
  localparam int         HOLD_CYCLES     = 400;

  typedef struct {
    logic [1:0] mode;
    req_t       req;
    bit         fixed;
    res_t       res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_data;
  logic        out_valid;
  logic        out_ready;
  res_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // console model state
  logic [6:0]       char_mem [TEXT_ROWS*TEXT_COLS];
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] top_off;
  logic [1:0]       cur_mode;
  logic [1:0]       cfg_raw;

  res_t new_res_q[$];
  res_t pending_res_q[$];
  res_t want_res;
  int   err_count = 0;
  int   req_count = 0;
  int   burst_left = 0;

  text_console_cursor_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("text_console_cursor_engine_unit test failed");
    $finish;
  end

  function automatic res_t make_res(bit ev, logic [7:0] eb, bit cv, logic [ROW_W-1:0] row,
                                    logic [COL_W-1:0] col, logic [6:0] ch, bit scr, bit clr);
    res_t r;
    r = '0;
    r.echo_valid = ev;
    r.echo_byte  = ev ? eb : 8'd0;
    r.cell_valid = cv;
    r.cell_row   = cv ? row : '0;
    r.cell_col   = cv ? col : '0;
    r.cell_char  = cv ? ch : 7'd0;
    r.scrolled   = scr;
    r.cleared    = clr;
    return r;
  endfunction

  function automatic res_t typed_res(bit ev, logic [7:0] eb, bit cv, logic [ROW_W-1:0] row,
                                     logic [COL_W-1:0] col, logic [6:0] ch, bit scr, bit clr);
    res_t r;
    r = make_res(ev, eb, cv, row, col, ch, scr, clr);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t tab_row(logic [1:0] mode, logic op, logic [7:0] ch, bit fixed,
                                        res_t res);
    stim_row_t t;
    t.mode           = mode;
    t.req.opcode     = op;
    t.req.char_code  = ch;
    t.fixed          = fixed;
    t.res            = res;
    return t;
  endfunction

  function automatic void console_clear();
    for (int i = 0; i < TEXT_ROWS*TEXT_COLS; i++) char_mem[i] = CH_SPACE[6:0];
    cur_col = '0;
    cur_row = '0;
    top_off = '0;
  endfunction

  function automatic void mem_write(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                    logic [6:0] ch);
    int phys;
    phys = (int'(top_off) + int'(row)) % TEXT_ROWS;
    if (col < TEXT_COLS) char_mem[phys*TEXT_COLS + int'(col)] = ch;
  endfunction

  // Move to the start of the next row; scroll when passing the last row.
  function automatic bit step_row();
    int old_top;
    cur_col = '0;
    cur_row = cur_row + 1'b1;
    if (cur_row >= TEXT_ROWS) begin
      old_top = int'(top_off) % TEXT_ROWS;
      for (int c = 0; c < TEXT_COLS; c++) char_mem[old_top*TEXT_COLS + c] = CH_SPACE[6:0];
      top_off = ROW_W'((old_top + 1) % TEXT_ROWS);
      cur_row = LAST_ROW;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void put_cell(bit echo, logic [7:0] eb, logic [6:0] ch);
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    bit               scr;
    row = cur_row;
    col = cur_col;
    scr = 1'b0;
    mem_write(row, col, ch);
    cur_col = cur_col + 1'b1;
    if (cur_col >= TEXT_COLS) scr = step_row();
    new_res_q.push_back(make_res(echo, eb, 1'b1, row, col, ch, scr, 1'b0));
  endfunction

  // Work out the result beats of one request into new_res_q.
  function automatic void predict_console(req_t r);
    logic [7:0] c;
    logic [6:0] ch;
    bit         echo;
    bit         scr;
    int         n_sp;
    res_t       tail;
    new_res_q.delete();
    if (r.opcode == OP_CLEAR) begin
      console_clear();
      new_res_q.push_back(make_res(1'b0, 8'd0, 1'b0, '0, '0, 7'd0, 1'b0,
                                   cur_mode != MODE_SERIAL));
    end else begin
      c = r.char_code;
      if (c == CH_DEL) c = CH_BS;
      echo = (cur_mode != MODE_DISPLAY);
      if (cur_mode == MODE_SERIAL) begin
        new_res_q.push_back(make_res(1'b1, c, 1'b0, '0, '0, 7'd0, 1'b0, 1'b0));
      end else if (c == CH_CR) begin
        cur_col = '0;
        new_res_q.push_back(make_res(echo, c, 1'b0, '0, '0, 7'd0, 1'b0, 1'b0));
      end else if (c == CH_LF) begin
        scr = step_row();
        new_res_q.push_back(make_res(echo, c, 1'b0, '0, '0, 7'd0, scr, 1'b0));
      end else if (c == CH_BS) begin
        if (cur_col > 0) cur_col = cur_col - 1'b1;
        mem_write(cur_row, cur_col, CH_SPACE[6:0]);
        new_res_q.push_back(make_res(echo, c, 1'b1, cur_row, cur_col, CH_SPACE[6:0],
                                     1'b0, 1'b0));
      end else if (c == CH_TAB) begin
        // fix the space count before the first write moves the cursor
        n_sp = 4 - int'(cur_col[1:0]);
        if (echo) new_res_q.push_back(make_res(1'b1, c, 1'b0, '0, '0, 7'd0, 1'b0, 1'b0));
        for (int i = 0; i < n_sp; i++) put_cell(echo, CH_SPACE, CH_SPACE[6:0]);
      end else begin
        ch = (c < CH_SPACE || c > CH_TILDE) ? CH_QMARK[6:0] : c[6:0];
        put_cell(echo, c, ch);
      end
    end
    tail = new_res_q.pop_back();
    tail.last = 1'b1;
    new_res_q.push_back(tail);
  endfunction

  task automatic send_request(req_t r, bit fixed, res_t fixed_res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    req_count++;
    predict_console(r);
    if (fixed) pending_res_q.push_back(fixed_res);
    else foreach (new_res_q[i]) pending_res_q.push_back(new_res_q[i]);
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] v);
    logic [1:0] sat;
    sat = (v == MODE_RESERVED) ? MODE_MIRROR : v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_OUTPUT_MODE;
    pwdata  <= {30'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'd0, sat}) begin
      $error("output_mode readback: expected %0d, got %0d", sat, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_mode = sat;
    cfg_raw  = v;
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_res_q.size() == 0) begin
        $error("result with nothing pending: %p", out_data);
        err_count++;
      end else begin
        want_res = pending_res_q.pop_front();
        cmp_field("echo_valid", want_res.echo_valid, out_data.echo_valid);
        cmp_field("echo_byte",  want_res.echo_byte,  out_data.echo_byte);
        cmp_field("cell_valid", want_res.cell_valid, out_data.cell_valid);
        cmp_field("cell_row",   want_res.cell_row,   out_data.cell_row);
        cmp_field("cell_col",   want_res.cell_col,   out_data.cell_col);
        cmp_field("cell_char",  want_res.cell_char,  out_data.cell_char);
        cmp_field("scrolled",   want_res.scrolled,   out_data.scrolled);
        cmp_field("cleared",    want_res.cleared,    out_data.cleared);
        cmp_field("last",       want_res.last,       out_data.last);
      end
    end
  end

  // Receiver: stretches of steady, random, sparse and toggling ready, plus
  // one long hold-off once the random traffic is under way.
  initial begin
    int  kind;
    int  len;
    bit  hold_done;
    hold_done = 1'b0;
    out_ready = 1'b1;
    forever begin
      kind = $urandom_range(0, 3);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(negedge clk);
        if (!hold_done && req_count >= HOLD_AT_REQ) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (kind)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
      end
    end
  end

  initial begin
    stim_row_t  dir_tab[$];
    int         rand_items;
    int         seg;
    int         kind;
    int         n;
    req_t       r;
    logic [1:0] modes [6];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    console_clear();
    cur_mode = MODE_MIRROR;
    cfg_raw  = MODE_MIRROR;
    modes    = '{MODE_SERIAL, MODE_DISPLAY, MODE_DISPLAY, MODE_MIRROR, MODE_MIRROR,
                 MODE_RESERVED};

    // mirror mode straight out of reset
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, 8'h41, 1,
                              typed_res(1, 8'h41, 1, 0, 0, 7'h41, 0, 0)));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, 8'h00, 1,
                              typed_res(1, 8'h00, 1, 0, 1, CH_QMARK[6:0], 0, 0)));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, 8'hFF, 1,
                              typed_res(1, 8'hFF, 1, 0, 2, CH_QMARK[6:0], 0, 0)));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_TILDE, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_SPACE, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, 8'd31, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_TAB, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_CR, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_TAB, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_BS, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_DEL, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_LF, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, 8'h80, 0, '0));
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_CLEAR, 8'hFF, 1,
                              typed_res(0, 0, 0, 0, 0, 0, 0, 1)));
    // backspace at column 0 blanks the cell without stepping back
    dir_tab.push_back(tab_row(MODE_MIRROR, OP_PUT, CH_BS, 1,
                              typed_res(1, CH_BS, 1, 0, 0, CH_SPACE[6:0], 0, 0)));
    dir_tab.push_back(tab_row(MODE_DISPLAY, OP_PUT, 8'h5A, 0, '0));
    dir_tab.push_back(tab_row(MODE_DISPLAY, OP_PUT, CH_TAB, 0, '0));
    dir_tab.push_back(tab_row(MODE_DISPLAY, OP_PUT, CH_LF, 0, '0));
    dir_tab.push_back(tab_row(MODE_DISPLAY, OP_PUT, CH_DEL, 0, '0));
    dir_tab.push_back(tab_row(MODE_SERIAL, OP_PUT, CH_DEL, 1,
                              typed_res(1, CH_BS, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(tab_row(MODE_SERIAL, OP_PUT, CH_TAB, 1,
                              typed_res(1, CH_TAB, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(tab_row(MODE_SERIAL, OP_CLEAR, 8'h5A, 1,
                              typed_res(0, 0, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(tab_row(MODE_SERIAL, OP_PUT, 8'h00, 1,
                              typed_res(1, 8'h00, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(tab_row(MODE_SERIAL, OP_PUT, CH_LF, 1,
                              typed_res(1, CH_LF, 0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(tab_row(MODE_RESERVED, OP_PUT, 8'h71, 0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != cfg_raw) begin
        wait_idle();
        write_mode(dir_tab[i].mode);
      end
      send_request(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].res);
    end

    rand_items = 0;
    seg = 0;
    while (rand_items < RAND_REQS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) n = $urandom_range(10, 45);
      else if (kind <= 5) n = $urandom_range(5, 35);
      else n = $urandom_range(3, 12);
      if (n > RAND_REQS - rand_items) n = RAND_REQS - rand_items;
      if (kind == 9) begin
        r.opcode    = OP_CLEAR;
        r.char_code = 8'($urandom_range(0, 255));
        send_request(r, 1'b0, '0);
        rand_items++;
      end
      repeat (n) begin
        r.opcode = OP_PUT;
        if (kind <= 3) begin
          // long lines wrap at the right edge
          if ($urandom_range(0, 7) == 0) r.char_code = CH_TAB;
          else if ($urandom_range(0, 15) == 0) r.char_code = $urandom_range(0, 1) ? CH_BS : CH_DEL;
          else r.char_code = 8'($urandom_range(32, 126));
        end else if (kind <= 5) begin
          // newline runs push the cursor past the last row
          r.char_code = ($urandom_range(0, 7) == 0) ? CH_CR : CH_LF;
        end else begin
          r.opcode    = ($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_PUT;
          r.char_code = 8'($urandom_range(0, 255));
        end
        send_request(r, 1'b0, '0);
        rand_items++;
      end
      seg++;
      // keep traffic flowing through the long receiver hold-off
      if (req_count > HOLD_AT_REQ + 60 && (seg % 4 == 0 || $urandom_range(0, 2) == 0)) begin
        wait_idle();
        if ($urandom_range(0, 1) == 1) write_mode(modes[$urandom_range(0, 5)]);
      end
    end

    in_valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("text_console_cursor_engine_unit test passed");
    end else begin
      $display("text_console_cursor_engine_unit test failed");
    end
    $finish;
  end

endmodule
